/* rtl/core/clcpa_pkg.sv */
package clcpa_pkg;

   // Field and register widths.
   localparam int RANGE_W = 20;
   localparam int ANGLE_W = 16;
   localparam int SPEED_W = 14;
   localparam int TCPA_W = 24;
   localparam int TLIM_W = 23;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 23;

   localparam int ANGLE_BITS_DEF = 16;
   localparam int CORDIC_STEPS = 30;
   localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

   localparam logic [47:0] VSQ_MIN = 48'd4294;
   localparam logic [23:0] TCPA_POS_MAX = 24'h7F_FFFF;
   localparam logic [23:0] TCPA_NEG_MAX = 24'h80_0000;
   localparam logic [19:0] DIST_MAX = 20'hF_FFFF;

   localparam logic [19:0] DCPA_HIGH_RST = 20'd18520;
   localparam logic [19:0] DCPA_LOW_RST = 20'd37040;
   localparam logic [22:0] TCPA_HIGH_RST = 23'd14400;
   localparam logic [22:0] TCPA_LOW_RST = 23'd28800;

   // Quotient widths of the two dividers.
   localparam int TCPA_QUO_BITS = 23;
   localparam int DIST_QUO_BITS = 44;

   typedef enum logic [1:0] {
      CSR_DCPA_HIGH = 2'd0,
      CSR_DCPA_LOW = 2'd1,
      CSR_TCPA_HIGH = 2'd2,
      CSR_TCPA_LOW = 2'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      RISK_NONE = 2'd0,
      RISK_LOW = 2'd1,
      RISK_HIGH = 2'd2
   } risk_type;

   typedef struct packed {
      logic [RANGE_W-1:0] target_range;
      logic [ANGLE_W-1:0] target_bearing;
      logic [SPEED_W-1:0] own_speed;
      logic [ANGLE_W-1:0] own_course;
      logic [SPEED_W-1:0] target_speed;
      logic [ANGLE_W-1:0] target_course;
   } req_type;

   typedef struct packed {
      logic [RANGE_W-1:0] closest_distance;
      logic signed [TCPA_W-1:0] time_to_closest;
      risk_type risk_class;
   } rsp_type;

   typedef struct packed {
      logic [1:0] q;
      logic signed [31:0] z;
   } angle_type;

   // Arctangent of 2^-i in 1/2^32 turn.
   function automatic logic signed [31:0] atan_turn(input int unsigned idx);
      case (idx)
         0: return 32'sd536870912;
         1: return 32'sd316933406;
         2: return 32'sd167458907;
         3: return 32'sd85004756;
         4: return 32'sd42667331;
         5: return 32'sd21354465;
         6: return 32'sd10680862;
         7: return 32'sd5340245;
         8: return 32'sd2670163;
         9: return 32'sd1335087;
         10: return 32'sd667544;
         11: return 32'sd333772;
         12: return 32'sd166886;
         13: return 32'sd83443;
         14: return 32'sd41721;
         15: return 32'sd20860;
         16: return 32'sd10430;
         17: return 32'sd5215;
         18: return 32'sd2607;
         19: return 32'sd1303;
         20: return 32'sd651;
         21: return 32'sd325;
         22: return 32'sd162;
         23: return 32'sd81;
         24: return 32'sd40;
         25: return 32'sd20;
         26: return 32'sd10;
         27: return 32'sd5;
         28: return 32'sd2;
         29: return 32'sd1;
         default: return 32'sd0;
      endcase
   endfunction

   // Quadrant reduction: the residual lies within an eighth of a turn of zero.
   function automatic angle_type angle_reduce(input logic [ANGLE_W-1:0] ang,
                                              input logic [31:0] mask);
      logic [31:0] a;
      logic [31:0] sum;
      logic [31:0] d;
      angle_type r;
      a = {ang, 16'h0000} & mask;
      sum = a + 32'h2000_0000;
      r.q = sum[31:30];
      d = a - {r.q, 30'd0};
      r.z = signed'(d);
      return r;
   endfunction

   // mag * trig / 256, rounded half up.
   function automatic logic signed [29:0] mul_round8(input logic [19:0] mag,
                                                     input logic signed [17:0] trig);
      logic signed [38:0] prod;
      prod = $signed({19'd0, mag}) * 39'(trig);
      prod = prod + 39'sd128;
      return 30'(prod >>> 8);
   endfunction

endpackage

/* rtl/core/collision_cpa_risk_classifier.sv */
// Channel        Ports                                Direction  Handshake
// request        start, busy, req_data                in         start high, busy low
// response       rsp_valid, rsp_data                  out        one-cycle strobe
// registers      csr_we, csr_index, csr_wdata         in         write on csr_we
//
// A new transaction is taken every cycle; busy is never raised.
// The response strobe follows the accepting edge through the 30-step sine/cosine pipeline,
// the product stages, the 44-step distance divider and the 22-step root.
// Reset (synchronous, active high) clears the valid bits and loads the limit registers.
// The receiver cannot stall, so nothing in the pipeline ever waits.
module collision_cpa_risk_classifier #(
   parameter int ANGLE_BITS = clcpa_pkg::ANGLE_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  clcpa_pkg::req_type req_data,
   output logic rsp_valid,
   output clcpa_pkg::rsp_type rsp_data,
   input  logic csr_we,
   input  logic [clcpa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [clcpa_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int CS = clcpa_pkg::CORDIC_STEPS;
   localparam int TQ = clcpa_pkg::TCPA_QUO_BITS;
   localparam int QW = clcpa_pkg::DIST_QUO_BITS;
   localparam int QH = QW / 2;
   localparam int DW = 52;
   localparam int RW = 64;
   localparam logic [31:0] ANG_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

   localparam int ST_TRIG = CS + 1;
   localparam int ST_M1 = CS + 2;
   localparam int ST_M2 = CS + 3;
   localparam int ST_M3 = CS + 4;
   localparam int ST_M4 = CS + 5;
   localparam int ST_M5 = CS + 6;
   localparam int ST_M6 = CS + 7;
   localparam int ST_M7 = CS + 8;
   localparam int T_DONE = ST_M6 + TQ + 1;
   localparam int ST_DDONE = ST_M7 + QW;
   localparam int ST_END = ST_DDONE + QH;
   localparam int FIN = ST_END + 1;

   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [31:0] z;
      logic [1:0] q;
   } cordic_type;

   typedef struct packed {
      logic [clcpa_pkg::RANGE_W-1:0] range;
      logic [clcpa_pkg::SPEED_W-1:0] own_spd;
      logic [clcpa_pkg::SPEED_W-1:0] tgt_spd;
   } side_type;

   typedef struct packed {
      logic signed [29:0] pe;
      logic signed [29:0] pn;
      logic signed [23:0] to_e;
      logic signed [23:0] to_n;
      logic signed [23:0] tt_e;
      logic signed [23:0] tt_n;
   } m1_type;

   typedef struct packed {
      logic signed [29:0] pe;
      logic signed [29:0] pn;
      logic signed [24:0] ve;
      logic signed [24:0] vn;
   } m2_type;

   typedef struct packed {
      logic signed [54:0] pe_ve;
      logic signed [54:0] pn_vn;
      logic signed [54:0] pe_vn;
      logic signed [54:0] pn_ve;
      logic [47:0] ve2;
      logic [47:0] vn2;
   } m3_type;

   typedef struct packed {
      logic signed [55:0] dot;
      logic signed [55:0] crs;
      logic [47:0] vsq;
   } m4_type;

   typedef struct packed {
      logic [53:0] num;
      logic neg;
      logic [53:0] ac;
      logic [DW-1:0] den;
      logic [47:0] vsq;
   } m5_type;

   typedef struct packed {
      logic [53:0] hh;
      logic [53:0] hl;
      logic [53:0] ll;
      logic [47:0] vsq;
   } m6_type;

   typedef struct packed {
      logic [DW-1:0] rem;
      logic [TQ-1:0] nq;
      logic [DW-1:0] den;
      logic ovf;
      logic neg;
   } tdiv_type;

   typedef struct packed {
      logic [RW-1:0] rem;
      logic [QW-1:0] nq;
      logic [RW-1:0] d;
   } ddiv_type;

   typedef struct packed {
      logic [QW-1:0] n;
      logic [QW-1:0] res;
   } root_type;

   logic vld_ff [0:FIN];
   logic vld_in [0:FIN];
   side_type side_ff [0:ST_END];
   side_type side_in [0:ST_END];
   cordic_type cor_ff [0:CS][0:2];
   cordic_type cor_in [0:CS][0:2];
   logic signed [17:0] sin_ff [0:2];
   logic signed [17:0] sin_in [0:2];
   logic signed [17:0] cos_ff [0:2];
   logic signed [17:0] cos_in [0:2];
   m1_type m1_ff, m1_in;
   m2_type m2_ff, m2_in;
   m3_type m3_ff, m3_in;
   m4_type m4_ff, m4_in;
   m5_type m5_ff, m5_in;
   m6_type m6_ff, m6_in;
   logic fast_ff [ST_M5:ST_END];
   logic fast_in [ST_M5:ST_END];
   tdiv_type tdv_ff [0:TQ];
   tdiv_type tdv_in [0:TQ];
   logic signed [23:0] tcpa_ff [T_DONE:ST_END];
   logic signed [23:0] tcpa_in [T_DONE:ST_END];
   ddiv_type ddv_ff [0:QW];
   ddiv_type ddv_in [0:QW];
   root_type sq_ff [1:QH];
   root_type sq_in [1:QH];
   root_type sq_src [1:QH];
   clcpa_pkg::rsp_type out_ff, out_in;

   logic [19:0] dh_ff, dh_in;
   logic [19:0] dl_ff, dl_in;
   logic [22:0] th_ff, th_in;
   logic [22:0] tl_ff, tl_in;

   assign busy = 1'b0;
   assign rsp_valid = vld_ff[FIN];
   assign rsp_data = out_ff;

   // Limit registers.
   always_comb begin
      dh_in = dh_ff;
      dl_in = dl_ff;
      th_in = th_ff;
      tl_in = tl_ff;
      if (csr_we) begin
         case (csr_index)
            clcpa_pkg::CSR_DCPA_HIGH: dh_in = csr_wdata[19:0];
            clcpa_pkg::CSR_DCPA_LOW: dl_in = csr_wdata[19:0];
            clcpa_pkg::CSR_TCPA_HIGH: th_in = csr_wdata[22:0];
            clcpa_pkg::CSR_TCPA_LOW: tl_in = csr_wdata[22:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dh_ff <= clcpa_pkg::DCPA_HIGH_RST;
         dl_ff <= clcpa_pkg::DCPA_LOW_RST;
         th_ff <= clcpa_pkg::TCPA_HIGH_RST;
         tl_ff <= clcpa_pkg::TCPA_LOW_RST;
      end else begin
         dh_ff <= dh_in;
         dl_ff <= dl_in;
         th_ff <= th_in;
         tl_ff <= tl_in;
      end
   end

   // Valid bits and the side data that rides along.
   always_comb begin
      vld_in[0] = start & ~busy;
      for (int k = 1; k <= FIN; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
      side_in[0].range = req_data.target_range;
      side_in[0].own_spd = req_data.own_speed;
      side_in[0].tgt_spd = req_data.target_speed;
      for (int k = 1; k <= ST_END; k++) begin
         side_in[k] = side_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= FIN; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         for (int k = 0; k <= FIN; k++) begin
            vld_ff[k] <= vld_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= ST_END; k++) begin
         side_ff[k] <= side_in[k];
      end
   end

   // Entry: quadrant reduction of the three angles.
   always_comb begin
      clcpa_pkg::angle_type ar [0:2];
      ar[0] = clcpa_pkg::angle_reduce(req_data.target_bearing, ANG_MASK);
      ar[1] = clcpa_pkg::angle_reduce(req_data.own_course, ANG_MASK);
      ar[2] = clcpa_pkg::angle_reduce(req_data.target_course, ANG_MASK);
      for (int l = 0; l < 3; l++) begin
         cor_in[0][l].x = clcpa_pkg::CORDIC_GAIN_Q30;
         cor_in[0][l].y = 34'sd0;
         cor_in[0][l].z = ar[l].z;
         cor_in[0][l].q = ar[l].q;
      end
   end

   // CORDIC rotation, one micro-rotation per stage in each of three lanes.
   for (genvar i = 0; i < CS; i++) begin : g_cordic
      for (genvar l = 0; l < 3; l++) begin : g_lane
         always_comb begin
            cor_in[i+1][l].q = cor_ff[i][l].q;
            if (cor_ff[i][l].z >= 0) begin
               cor_in[i+1][l].x = cor_ff[i][l].x - (cor_ff[i][l].y >>> i);
               cor_in[i+1][l].y = cor_ff[i][l].y + (cor_ff[i][l].x >>> i);
               cor_in[i+1][l].z = cor_ff[i][l].z - clcpa_pkg::atan_turn(i);
            end else begin
               cor_in[i+1][l].x = cor_ff[i][l].x + (cor_ff[i][l].y >>> i);
               cor_in[i+1][l].y = cor_ff[i][l].y - (cor_ff[i][l].x >>> i);
               cor_in[i+1][l].z = cor_ff[i][l].z + clcpa_pkg::atan_turn(i);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= CS; i++) begin
         for (int l = 0; l < 3; l++) begin
            cor_ff[i][l] <= cor_in[i][l];
         end
      end
   end

   // Round to Q16 and undo the quadrant reduction.
   always_comb begin
      logic signed [33:0] cr;
      logic signed [33:0] sr;
      logic signed [17:0] c;
      logic signed [17:0] s;
      for (int l = 0; l < 3; l++) begin
         cr = (cor_ff[CS][l].x + 34'sd8192) >>> 14;
         sr = (cor_ff[CS][l].y + 34'sd8192) >>> 14;
         c = cr[17:0];
         s = sr[17:0];
         case (cor_ff[CS][l].q)
            2'd0: begin
               cos_in[l] = c;
               sin_in[l] = s;
            end
            2'd1: begin
               cos_in[l] = -s;
               sin_in[l] = c;
            end
            2'd2: begin
               cos_in[l] = -c;
               sin_in[l] = -s;
            end
            default: begin
               cos_in[l] = s;
               sin_in[l] = -c;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < 3; l++) begin
         sin_ff[l] <= sin_in[l];
         cos_ff[l] <= cos_in[l];
      end
   end

   // Position and velocity components.
   always_comb begin
      m1_in.pe = clcpa_pkg::mul_round8(side_ff[ST_TRIG].range, sin_ff[0]);
      m1_in.pn = clcpa_pkg::mul_round8(side_ff[ST_TRIG].range, cos_ff[0]);
      m1_in.to_e = 24'(clcpa_pkg::mul_round8({6'd0, side_ff[ST_TRIG].own_spd}, sin_ff[1]));
      m1_in.to_n = 24'(clcpa_pkg::mul_round8({6'd0, side_ff[ST_TRIG].own_spd}, cos_ff[1]));
      m1_in.tt_e = 24'(clcpa_pkg::mul_round8({6'd0, side_ff[ST_TRIG].tgt_spd}, sin_ff[2]));
      m1_in.tt_n = 24'(clcpa_pkg::mul_round8({6'd0, side_ff[ST_TRIG].tgt_spd}, cos_ff[2]));

      m2_in.pe = m1_ff.pe;
      m2_in.pn = m1_ff.pn;
      m2_in.ve = 25'(m1_ff.tt_e) - 25'(m1_ff.to_e);
      m2_in.vn = 25'(m1_ff.tt_n) - 25'(m1_ff.to_n);

      m3_in.pe_ve = 55'(m2_ff.pe) * 55'(m2_ff.ve);
      m3_in.pn_vn = 55'(m2_ff.pn) * 55'(m2_ff.vn);
      m3_in.pe_vn = 55'(m2_ff.pe) * 55'(m2_ff.vn);
      m3_in.pn_ve = 55'(m2_ff.pn) * 55'(m2_ff.ve);
      m3_in.ve2 = 48'(50'(m2_ff.ve) * 50'(m2_ff.ve));
      m3_in.vn2 = 48'(50'(m2_ff.vn) * 50'(m2_ff.vn));

      m4_in.dot = 56'(m3_ff.pe_ve) + 56'(m3_ff.pn_vn);
      m4_in.crs = 56'(m3_ff.pe_vn) - 56'(m3_ff.pn_ve);
      m4_in.vsq = m3_ff.ve2 + m3_ff.vn2;

      // A positive dot product means the target is opening: the time is negative.
      m5_in.neg = m4_ff.dot > 56'sd0;
      m5_in.num = (m4_ff.dot < 56'sd0) ? 54'(-m4_ff.dot) : 54'(m4_ff.dot);
      m5_in.ac = (m4_ff.crs < 56'sd0) ? 54'(-m4_ff.crs) : 54'(m4_ff.crs);
      m5_in.den = DW'({m4_ff.vsq, 3'd0}) + DW'({m4_ff.vsq, 1'd0});
      m5_in.vsq = m4_ff.vsq;
      fast_in[ST_M5] = m4_ff.vsq > clcpa_pkg::VSQ_MIN;
      for (int k = ST_M5 + 1; k <= ST_END; k++) begin
         fast_in[k] = fast_ff[k-1];
      end

      // Square of the cross product from three partial products.
      m6_in.hh = 54'(m5_ff.ac[53:27]) * 54'(m5_ff.ac[53:27]);
      m6_in.hl = 54'(m5_ff.ac[53:27]) * 54'(m5_ff.ac[26:0]);
      m6_in.ll = 54'(m5_ff.ac[26:0]) * 54'(m5_ff.ac[26:0]);
      m6_in.vsq = m5_ff.vsq;

      // The time quotient saturates when it would reach 2^23 before rounding.
      tdv_in[0].rem = DW'(m5_ff.num[53:11]);
      tdv_in[0].nq = {m5_ff.num[10:0], 12'd0};
      tdv_in[0].den = m5_ff.den;
      tdv_in[0].ovf = DW'(m5_ff.num[53:11]) >= m5_ff.den;
      tdv_in[0].neg = m5_ff.neg;
   end

   always_ff @(posedge clock) begin
      m1_ff <= m1_in;
      m2_ff <= m2_in;
      m3_ff <= m3_in;
      m4_ff <= m4_in;
      m5_ff <= m5_in;
      m6_ff <= m6_in;
      for (int k = ST_M5; k <= ST_END; k++) begin
         fast_ff[k] <= fast_in[k];
      end
   end

   // Time divider: one restoring step per stage.
   for (genvar j = 1; j <= TQ; j++) begin : g_tdiv
      always_comb begin
         logic [DW:0] rs;
         logic ge;
         rs = {tdv_ff[j-1].rem, tdv_ff[j-1].nq[TQ-1]};
         ge = rs >= {1'b0, tdv_ff[j-1].den};
         tdv_in[j] = tdv_ff[j-1];
         tdv_in[j].rem = ge ? DW'(rs - {1'b0, tdv_ff[j-1].den}) : rs[DW-1:0];
         tdv_in[j].nq = {tdv_ff[j-1].nq[TQ-2:0], ge};
      end
   end

   // Round half up, saturate and apply the sign.
   always_comb begin
      logic [23:0] mag;
      logic rnd;
      rnd = {tdv_ff[TQ].rem, 1'b0} >= {1'b0, tdv_ff[TQ].den};
      mag = tdv_ff[TQ].ovf ? clcpa_pkg::TCPA_NEG_MAX : 24'(tdv_ff[TQ].nq) + 24'(rnd);
      if (tdv_ff[TQ].neg) begin
         tcpa_in[T_DONE] = signed'(24'(-mag));
      end else if (mag > clcpa_pkg::TCPA_POS_MAX) begin
         tcpa_in[T_DONE] = signed'(clcpa_pkg::TCPA_POS_MAX);
      end else begin
         tcpa_in[T_DONE] = signed'(mag);
      end
      for (int k = T_DONE + 1; k <= ST_END; k++) begin
         tcpa_in[k] = tcpa_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j <= TQ; j++) begin
         tdv_ff[j] <= tdv_in[j];
      end
      for (int k = T_DONE; k <= ST_END; k++) begin
         tcpa_ff[k] <= tcpa_in[k];
      end
   end

   // Distance: cross^2 / (vsq * 2^16); the quotient stays below 2^44.
   always_comb begin
      logic [107:0] sq;
      sq = (108'(m6_ff.hh) << 54) + (108'(m6_ff.hl) << 28) + 108'(m6_ff.ll);
      ddv_in[0].rem = sq[107:QW];
      ddv_in[0].nq = sq[QW-1:0];
      ddv_in[0].d = {m6_ff.vsq, 16'd0};
   end

   for (genvar j = 1; j <= QW; j++) begin : g_ddiv
      always_comb begin
         logic [RW:0] rs;
         logic ge;
         rs = {ddv_ff[j-1].rem, ddv_ff[j-1].nq[QW-1]};
         ge = rs >= {1'b0, ddv_ff[j-1].d};
         ddv_in[j] = ddv_ff[j-1];
         ddv_in[j].rem = ge ? RW'(rs - {1'b0, ddv_ff[j-1].d}) : rs[RW-1:0];
         ddv_in[j].nq = {ddv_ff[j-1].nq[QW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j <= QW; j++) begin
         ddv_ff[j] <= ddv_in[j];
      end
   end

   // Integer square root, two bits of the radicand per stage.
   for (genvar k = 1; k <= QH; k++) begin : g_root
      if (k == 1) begin : g_first
         assign sq_src[k] = '{n: ddv_ff[QW].nq, res: '0};
      end else begin : g_next
         assign sq_src[k] = sq_ff[k-1];
      end
      always_comb begin
         logic [QW-1:0] t;
         t = sq_src[k].res + (QW'(1) << (QW - 2 * k));
         if (sq_src[k].n >= t) begin
            sq_in[k].n = sq_src[k].n - t;
            sq_in[k].res = (sq_src[k].res >> 1) + (QW'(1) << (QW - 2 * k));
         end else begin
            sq_in[k].n = sq_src[k].n;
            sq_in[k].res = sq_src[k].res >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 1; k <= QH; k++) begin
         sq_ff[k] <= sq_in[k];
      end
   end

   // Result and risk class.
   always_comb begin
      logic [19:0] dist_v;
      logic signed [23:0] tc;
      if (fast_ff[ST_END]) begin
         tc = tcpa_ff[ST_END];
         dist_v = (sq_ff[QH].res > QW'(clcpa_pkg::DIST_MAX)) ?
                  clcpa_pkg::DIST_MAX : sq_ff[QH].res[19:0];
      end else begin
         tc = 24'sd0;
         dist_v = side_ff[ST_END].range;
      end
      out_in.closest_distance = dist_v;
      out_in.time_to_closest = tc;
      out_in.risk_class = clcpa_pkg::RISK_NONE;
      if (!tc[23]) begin
         if (dist_v <= dh_ff && tc[22:0] <= th_ff) begin
            out_in.risk_class = clcpa_pkg::RISK_HIGH;
         end else if (dist_v <= dl_ff && tc[22:0] <= tl_ff) begin
            out_in.risk_class = clcpa_pkg::RISK_LOW;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(FIN + 1) rsp_valid)
      else $error("accepted transaction did not produce a response in time");

   a_passed_no_risk: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.time_to_closest[23]) |->
      rsp_data.risk_class == clcpa_pkg::RISK_NONE)
      else $error("passed target classed as a risk");

   a_high_dist: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.risk_class == clcpa_pkg::RISK_HIGH) |->
      rsp_data.closest_distance <= dh_ff)
      else $error("high risk beyond the distance limit");

   a_slow_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.time_to_closest != 24'sd0) |-> $past(fast_ff[ST_END]))
      else $error("non-zero time for a near-zero relative speed");

endmodule

/* dv/collision_cpa_risk_classifier_tb.sv */
`timescale 1ns / 100ps

module collision_cpa_risk_classifier_tb;

   localparam int LATENCY = 105;
   localparam int IDLE_LIMIT = 5000;
   localparam int RANDOM_ITEMS = 1130;

   // Arctangent of 2^-i, in 1/2^32 turn.
   localparam longint ATAN_TBL [30] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41721, 20860, 10430, 5215, 2607, 1303, 651, 325, 162, 81, 40, 20,
      10, 5, 2, 1
   };

   class cpa_scoreboard;
      clcpa_pkg::rsp_type expected_q[$];
      logic [19:0] dcpa_high;
      logic [19:0] dcpa_low;
      logic [22:0] tcpa_high;
      logic [22:0] tcpa_low;
      int errors;

      function new();
         errors = 0;
         dcpa_high = clcpa_pkg::DCPA_HIGH_RST;
         dcpa_low = clcpa_pkg::DCPA_LOW_RST;
         tcpa_high = clcpa_pkg::TCPA_HIGH_RST;
         tcpa_low = clcpa_pkg::TCPA_LOW_RST;
      endfunction

      task report(input string what);
         errors++;
         $display("mismatch at %0t: %s", $time, what);
      endtask

      function void set_limit(input clcpa_pkg::csr_idx_type idx, input logic [22:0] val);
         case (idx)
            clcpa_pkg::CSR_DCPA_HIGH: dcpa_high = val[19:0];
            clcpa_pkg::CSR_DCPA_LOW: dcpa_low = val[19:0];
            clcpa_pkg::CSR_TCPA_HIGH: tcpa_high = val;
            clcpa_pkg::CSR_TCPA_LOW: tcpa_low = val;
            default: ;
         endcase
      endfunction

      function longint rnd8(input longint v);
         return (v + 128) >>> 8;
      endfunction

      // Quadrant reduction, then a rotation towards zero residual angle.
      function void trig_q16(input logic [15:0] ang, output longint sn, output longint cs);
         logic [31:0] a;
         logic [31:0] d;
         logic [1:0] quad;
         longint z, x, y, xn, c, s;
         a = {ang, 16'h0000};
         quad = 2'((a + 32'h2000_0000) >> 30);
         d = a - {quad, 30'd0};
         z = longint'($signed(d));
         x = 652032874;
         y = 0;
         for (int i = 0; i < 30; i++) begin
            if (z >= 0) begin
               xn = x - (y >>> i);
               y = y + (x >>> i);
               z -= ATAN_TBL[i];
            end else begin
               xn = x + (y >>> i);
               y = y - (x >>> i);
               z += ATAN_TBL[i];
            end
            x = xn;
         end
         c = (x + 8192) >>> 14;
         s = (y + 8192) >>> 14;
         case (quad)
            2'd0: begin cs = c; sn = s; end
            2'd1: begin cs = -s; sn = c; end
            2'd2: begin cs = -c; sn = -s; end
            default: begin cs = s; sn = -c; end
         endcase
      endfunction

      function longint unsigned int_sqrt(input longint unsigned n);
         longint unsigned res, bitv;
         res = 0;
         bitv = 64'd1 << 62;
         while (bitv > n) bitv >>= 2;
         while (bitv != 0) begin
            if (n >= res + bitv) begin
               n -= res + bitv;
               res = (res >> 1) + bitv;
            end else begin
               res >>= 1;
            end
            bitv >>= 2;
         end
         return res;
      endfunction

      function void note_request(input clcpa_pkg::req_type r);
         longint sb, cb, so, co, st, ct;
         longint pe, pn, ve, vn, dot, crs, tcpa;
         longint unsigned vsq, dist_v, num, den, q0, rem, mag, ac;
         logic [127:0] sq;
         logic [127:0] quo;
         clcpa_pkg::rsp_type e;
         tcpa = 0;
         dist_v = r.target_range;
         trig_q16(r.target_bearing, sb, cb);
         trig_q16(r.own_course, so, co);
         trig_q16(r.target_course, st, ct);
         pe = rnd8(longint'(r.target_range) * sb);
         pn = rnd8(longint'(r.target_range) * cb);
         ve = rnd8(longint'(r.target_speed) * st) - rnd8(longint'(r.own_speed) * so);
         vn = rnd8(longint'(r.target_speed) * ct) - rnd8(longint'(r.own_speed) * co);
         vsq = ve * ve + vn * vn;
         if (vsq > 4294) begin
            dot = pe * ve + pn * vn;
            num = (dot < 0) ? -dot : dot;
            den = vsq * 10;
            q0 = num / den;
            rem = num % den;
            if (q0 >= 2048) begin
               mag = 8388608;
            end else begin
               mag = (q0 << 12) + (rem << 12) / den;
               if (((rem << 12) % den) * 2 >= den) mag++;
            end
            if (dot > 0) begin
               if (mag > 8388608) mag = 8388608;
               tcpa = -longint'(mag);
            end else begin
               if (mag > 8388607) mag = 8388607;
               tcpa = mag;
            end
            crs = pe * vn - pn * ve;
            ac = (crs < 0) ? -crs : crs;
            sq = 128'(ac) * 128'(ac);
            quo = sq / (128'(vsq) << 16);
            dist_v = int_sqrt(quo[63:0]);
            if (dist_v > 1048575) dist_v = 1048575;
         end
         e.closest_distance = dist_v[19:0];
         e.time_to_closest = tcpa[23:0];
         e.risk_class = clcpa_pkg::RISK_NONE;
         if (tcpa >= 0) begin
            if (dist_v <= dcpa_high && tcpa <= tcpa_high)
               e.risk_class = clcpa_pkg::RISK_HIGH;
            else if (dist_v <= dcpa_low && tcpa <= tcpa_low)
               e.risk_class = clcpa_pkg::RISK_LOW;
         end
         expected_q.push_back(e);
      endfunction

      task check_response(input clcpa_pkg::rsp_type got);
         clcpa_pkg::rsp_type e;
         if (expected_q.size() == 0) begin
            report("response with no transaction outstanding");
         end else begin
            e = expected_q.pop_front();
            if (got.closest_distance !== e.closest_distance)
               report($sformatf("closest_distance %0d, expected %0d",
                                got.closest_distance, e.closest_distance));
            if (got.time_to_closest !== e.time_to_closest)
               report($sformatf("time_to_closest %0d, expected %0d",
                                got.time_to_closest, e.time_to_closest));
            if (got.risk_class !== e.risk_class)
               report($sformatf("risk_class %0d, expected %0d",
                                got.risk_class, e.risk_class));
         end
      endtask
   endclass

   logic clock;
   logic reset;
   logic start;
   logic busy;
   clcpa_pkg::req_type req_data;
   logic rsp_valid;
   clcpa_pkg::rsp_type rsp_data;
   logic csr_we;
   logic [clcpa_pkg::CSR_IDX_W-1:0] csr_index;
   logic [clcpa_pkg::CSR_DATA_W-1:0] csr_wdata;

   cpa_scoreboard sb = new();
   int idle_cycles;
   bit accepted_now;
   bit burst_mode;

   collision_cpa_risk_classifier u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         sb.check_response(rsp_data);
         accepted_now = 1'b1;
      end
   end

   // The run is stuck if no transaction moves on either channel for too long.
   always @(negedge clock) begin
      if (accepted_now) idle_cycles = 0;
      else idle_cycles++;
      accepted_now = 1'b0;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task send_target(input clcpa_pkg::req_type r);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      sb.note_request(r);
      accepted_now = 1'b1;
      @(negedge clock);
   endtask

   task drain;
      start <= 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
   endtask

   task write_limit(input clcpa_pkg::csr_idx_type idx, input logic [22:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.set_limit(idx, val);
   endtask

   task write_limits(input logic [19:0] dh, input logic [19:0] dl,
                     input logic [22:0] th, input logic [22:0] tl);
      write_limit(clcpa_pkg::CSR_DCPA_HIGH, 23'(dh));
      write_limit(clcpa_pkg::CSR_DCPA_LOW, 23'(dl));
      write_limit(clcpa_pkg::CSR_TCPA_HIGH, th);
      write_limit(clcpa_pkg::CSR_TCPA_LOW, tl);
   endtask

   function clcpa_pkg::req_type make_target(input logic [19:0] rng, input logic [15:0] brg,
                                            input logic [13:0] os, input logic [15:0] oc,
                                            input logic [13:0] ts, input logic [15:0] tc);
      clcpa_pkg::req_type r;
      r.target_range = rng;
      r.target_bearing = brg;
      r.own_speed = os;
      r.own_course = oc;
      r.target_speed = ts;
      r.target_course = tc;
      return r;
   endfunction

   function clcpa_pkg::req_type random_target();
      clcpa_pkg::req_type r;
      int kind;
      kind = $urandom_range(0, 9);
      r = make_target(20'($urandom_range(0, 20'hF_FFFF)), 16'($urandom_range(0, 65535)),
                      14'($urandom_range(0, 16383)), 16'($urandom_range(0, 65535)),
                      14'($urandom_range(0, 16383)), 16'($urandom_range(0, 65535)));
      if (kind < 4) begin
         // Close encounters, where the risk limits actually matter.
         r.target_range = 20'($urandom_range(0, 60000));
         r.own_speed = 14'($urandom_range(0, 4000));
         r.target_speed = 14'($urandom_range(0, 4000));
      end else if (kind == 4) begin
         // Matched velocities: relative speed near zero.
         r.target_speed = r.own_speed + 14'($urandom_range(0, 1));
         r.target_course = r.own_course + 16'($urandom_range(0, 2));
      end else if (kind == 5) begin
         r.own_speed = 14'($urandom_range(0, 3));
         r.target_speed = 14'($urandom_range(0, 3));
      end
      return r;
   endfunction

   task random_phase(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 60 == 0) burst_mode = ($urandom_range(0, 2) == 0);
         send_target(random_target());
      end
      burst_mode = 1'b0;
      drain();
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      idle_cycles = 0;
      accepted_now = 1'b0;
      burst_mode = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed cases under the reset limits.
      send_target(make_target(20'd0, 16'd0, 14'd0, 16'd0, 14'd0, 16'd0));
      send_target(make_target(20'hF_FFFF, 16'hFFFF, 14'h3FFF, 16'hFFFF, 14'h3FFF, 16'hFFFF));
      send_target(make_target(20'd5000, 16'h4000, 14'd2000, 16'h4000, 14'd2000, 16'h4000));
      send_target(make_target(20'd10000, 16'h0000, 14'd1000, 16'h0000, 14'd1000, 16'h8000));
      send_target(make_target(20'd10000, 16'h0000, 14'd1000, 16'h8000, 14'd1000, 16'h0000));
      send_target(make_target(20'd10000, 16'h8000, 14'd1000, 16'h8000, 14'd0, 16'h0000));
      send_target(make_target(20'd30000, 16'hC000, 14'd0, 16'h0000, 14'd3000, 16'h4000));
      send_target(make_target(20'd18000, 16'h2000, 14'd500, 16'h1FFF, 14'd500, 16'hA000));
      send_target(make_target(20'hF_FFFF, 16'h0000, 14'd0, 16'h0000, 14'd1, 16'h8000));
      send_target(make_target(20'hF_FFFF, 16'h0000, 14'd0, 16'h0000, 14'd1, 16'h0000));
      send_target(make_target(20'hF_FFFF, 16'h6000, 14'h3FFF, 16'hE000, 14'h3FFF, 16'h6000));
      send_target(make_target(20'd0, 16'h1234, 14'h3FFF, 16'h0000, 14'h3FFF, 16'h8000));
      send_target(make_target(20'd1, 16'h0000, 14'd0, 16'h0000, 14'd1, 16'h4000));
      send_target(make_target(20'd40000, 16'h4000, 14'd800, 16'hC000, 14'd0, 16'h0000));
      send_target(make_target(20'd20000, 16'hE000, 14'd0, 16'h0000, 14'd600, 16'h6000));
      send_target(make_target(20'd2, 16'h0000, 14'd0, 16'h0000, 14'd1, 16'h0001));
      send_target(make_target(20'd100, 16'h0001, 14'd16383, 16'h7FFF, 14'd16382, 16'h7FFF));
      drain();
      repeat (LATENCY) @(negedge clock);

      random_phase(RANDOM_ITEMS / 5);
      write_limits(20'hF_FFFF, 20'hF_FFFF, 23'h7F_FFFF, 23'h7F_FFFF);
      random_phase(RANDOM_ITEMS / 5);
      write_limits(20'd0, 20'd0, 23'd0, 23'd0);
      random_phase(RANDOM_ITEMS / 5);
      write_limits(20'd40000, 20'd10000, 23'd3000, 23'd60000);
      random_phase(RANDOM_ITEMS / 5);
      write_limits(20'($urandom_range(0, 60000)), 20'($urandom_range(0, 120000)),
                   23'($urandom_range(0, 40000)), 23'($urandom_range(0, 400000)));
      random_phase(RANDOM_ITEMS / 5);

      repeat (LATENCY + 20) @(negedge clock);
      if (sb.expected_q.size() != 0)
         sb.report($sformatf("%0d responses never arrived", sb.expected_q.size()));
      if (sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
